// File: design/psta_pkg.sv
// psta_pkg: item types, field widths and codes of the per-symbol trade aggregator
`timescale 1ns / 1ps

package psta_pkg;

    // fixed field widths
    localparam int SYM_IDX_W = 10;
    localparam int PRICE_W   = 32;
    localparam int QTY_W     = 24;
    localparam int TOT_W     = 40;
    localparam int VAL_W     = 63;
    localparam int PROD_W    = PRICE_W + QTY_W;

    // parameter defaults
    localparam int DEF_SYMBOL_SLOTS = 1024;
    localparam int DEF_PRICE_BITS   = 32;
    localparam int DEF_QTY_BITS     = 24;

    // action and side codes
    localparam logic ACT_APPLY = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [SYM_IDX_W-1:0] symbol_index;
        logic [PRICE_W-1:0]   price_ticks;
        logic [QTY_W-1:0]     quantity;
        logic                 side;
    } t_in_item;

    typedef struct packed {
        logic [TOT_W-1:0]   sym_buy_total;
        logic [TOT_W-1:0]   sym_sell_total;
        logic [VAL_W-1:0]   sym_value_total;
        logic [PRICE_W-1:0] sym_low_price;
        logic [PRICE_W-1:0] sym_high_price;
        logic               sym_seen;
        logic [TOT_W-1:0]   all_buy_total;
        logic [TOT_W-1:0]   all_sell_total;
        logic [VAL_W-1:0]   all_value_total;
        logic [PRICE_W-1:0] all_low_price;
        logic [PRICE_W-1:0] all_high_price;
    } t_out_item;

    // one slot's running figures, as held in the slot memory
    typedef struct packed {
        logic [TOT_W-1:0]   buy;
        logic [TOT_W-1:0]   sell;
        logic [VAL_W-1:0]   value;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] high;
    } t_figures;

endpackage

// File: design/per_symbol_trade_aggregator.sv
// per_symbol_trade_aggregator: per-slot and portfolio sum, min and max of trades
// result: the item and its slot read are registered at accept, and the result is loaded
//   into the output register in the update state, which waits while the previous result is not taken
// flow: no new item is taken until the slot write-back of the current one is done
// reset: after i_rst_n the slot valid memory is cleared one entry a cycle,
//   over all SYMBOL_SLOTS entries, with o_in_ready low; portfolio figures reset at once
`timescale 1ns / 1ps

module per_symbol_trade_aggregator #(
    parameter int SYMBOL_SLOTS = psta_pkg::DEF_SYMBOL_SLOTS,
    parameter int PRICE_BITS   = psta_pkg::DEF_PRICE_BITS,
    parameter int QTY_BITS     = psta_pkg::DEF_QTY_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  psta_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output psta_pkg::t_out_item o_out_item
);

    localparam int ADDR_W = $clog2(SYMBOL_SLOTS);
    localparam int EXT_W  = psta_pkg::SYM_IDX_W + ADDR_W;
    localparam int PW     = psta_pkg::PRICE_W;
    localparam int QW     = psta_pkg::QTY_W;
    localparam int TW     = psta_pkg::TOT_W;
    localparam int VW     = psta_pkg::VAL_W;

    // price and quantity bits at and above the configured widths are ignored
    localparam logic [PW-1:0] PRICE_MAX = PW'((64'd1 << PRICE_BITS) - 64'd1);
    localparam logic [QW-1:0] QTY_MASK  = QW'((64'd1 << QTY_BITS) - 64'd1);

    // one-hot control states
    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // slot memories: figures (never cleared) and valid marks (cleared after reset)
    psta_pkg::t_figures r_fig_mem [SYMBOL_SLOTS];
    logic               r_vld_mem [SYMBOL_SLOTS];
    psta_pkg::t_figures r_rd_fig;
    logic               r_rd_vld;

    logic [ADDR_W-1:0] r_clr_idx;

    // item held for the update cycle
    logic                      r_action;
    logic                      r_side;
    logic [PW-1:0]             r_price;
    logic [QW-1:0]             r_qty;
    logic [psta_pkg::PROD_W-1:0] r_prod;
    logic [ADDR_W-1:0]         r_addr;
    logic                      r_in_range;

    // portfolio figures
    psta_pkg::t_figures r_port;

    // output register
    logic                r_out_valid;
    psta_pkg::t_out_item r_out_item;

    // input side decode
    logic                        w_accept;
    logic [EXT_W-1:0]            w_idx_ext;
    logic                        w_in_range;
    logic [ADDR_W-1:0]           w_rd_addr;
    logic [PW-1:0]               w_price_m;
    logic [QW-1:0]               w_qty_m;
    logic [psta_pkg::PROD_W-1:0] w_prod;

    // update cycle
    logic               w_load;
    logic               w_apply;
    logic               w_slot_wr;
    logic               w_old_seen;
    psta_pkg::t_figures w_empty;
    psta_pkg::t_figures w_slot_old;
    psta_pkg::t_figures w_slot_new;
    psta_pkg::t_figures w_port_new;
    logic [TW:0]        w_sbuy_sum, w_ssell_sum, w_pbuy_sum, w_psell_sum;
    logic [VW:0]        w_sval_sum, w_pval_sum;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // index range check against the slot count, which may exceed the index field
    assign w_idx_ext  = EXT_W'(i_in_item.symbol_index);
    assign w_in_range = (w_idx_ext < EXT_W'(SYMBOL_SLOTS));
    assign w_rd_addr  = w_idx_ext[ADDR_W-1:0];
    assign w_price_m  = i_in_item.price_ticks & PRICE_MAX;
    assign w_qty_m    = i_in_item.quantity & QTY_MASK;
    assign w_prod     = w_price_m * w_qty_m;

    // update happens once the output register is free or being emptied
    assign w_load    = (r_state == S_UPDATE) && (!r_out_valid || i_out_ready);
    assign w_apply   = (r_action == psta_pkg::ACT_APPLY);
    assign w_slot_wr = w_load && w_apply && r_in_range;

    always_comb begin
        w_empty = '{buy: '0, sell: '0, value: '0, low: PRICE_MAX, high: '0};
    end

    // a never-written or out-of-range slot starts from the empty figures
    assign w_old_seen = r_in_range && r_rd_vld;
    assign w_slot_old = w_old_seen ? r_rd_fig : w_empty;

    // saturating sums, one bit wider to catch the carry
    assign w_sbuy_sum  = {1'b0, w_slot_old.buy}   + (TW+1)'(r_qty);
    assign w_ssell_sum = {1'b0, w_slot_old.sell}  + (TW+1)'(r_qty);
    assign w_sval_sum  = {1'b0, w_slot_old.value} + (VW+1)'(r_prod);
    assign w_pbuy_sum  = {1'b0, r_port.buy}       + (TW+1)'(r_qty);
    assign w_psell_sum = {1'b0, r_port.sell}      + (TW+1)'(r_qty);
    assign w_pval_sum  = {1'b0, r_port.value}     + (VW+1)'(r_prod);

    always_comb begin
        w_slot_new = w_slot_old;
        if (w_apply && r_in_range) begin
            if (r_side == psta_pkg::SIDE_BUY) begin
                w_slot_new.buy = w_sbuy_sum[TW] ? {TW{1'b1}} : w_sbuy_sum[TW-1:0];
            end else begin
                w_slot_new.sell = w_ssell_sum[TW] ? {TW{1'b1}} : w_ssell_sum[TW-1:0];
            end
            w_slot_new.value = w_sval_sum[VW] ? {VW{1'b1}} : w_sval_sum[VW-1:0];
            if (r_price < w_slot_old.low) begin
                w_slot_new.low = r_price;
            end
            if (r_price > w_slot_old.high) begin
                w_slot_new.high = r_price;
            end
        end
    end

    always_comb begin
        w_port_new = r_port;
        if (w_apply) begin
            if (r_side == psta_pkg::SIDE_BUY) begin
                w_port_new.buy = w_pbuy_sum[TW] ? {TW{1'b1}} : w_pbuy_sum[TW-1:0];
            end else begin
                w_port_new.sell = w_psell_sum[TW] ? {TW{1'b1}} : w_psell_sum[TW-1:0];
            end
            w_port_new.value = w_pval_sum[VW] ? {VW{1'b1}} : w_pval_sum[VW-1:0];
            if (r_price < r_port.low) begin
                w_port_new.low = r_price;
            end
            if (r_price > r_port.high) begin
                w_port_new.high = r_price;
            end
        end
    end

    // control state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == ADDR_W'(SYMBOL_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_port      <= w_empty;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_port      <= w_port_new;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // slot figure memory: read at accept, written back in the update cycle
    always_ff @(posedge i_clk) begin
        if (w_slot_wr) begin
            r_fig_mem[r_addr] <= w_slot_new;
        end
        if (w_accept) begin
            r_rd_fig <= r_fig_mem[w_rd_addr];
        end
    end

    // valid memory: clearing pass after reset, then set by each slot write
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_vld_mem[r_clr_idx] <= 1'b0;
        end else if (w_slot_wr) begin
            r_vld_mem[r_addr] <= 1'b1;
        end
        if (w_accept) begin
            r_rd_vld <= r_vld_mem[w_rd_addr];
        end
    end

    // item payload, product registered ahead of the saturating add
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action   <= i_in_item.action;
            r_side     <= i_in_item.side;
            r_price    <= w_price_m;
            r_qty      <= w_qty_m;
            r_prod     <= w_prod;
            r_addr     <= w_rd_addr;
            r_in_range <= w_in_range;
        end
    end

    // result item shows the state after the step
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item.sym_buy_total   <= w_slot_new.buy;
            r_out_item.sym_sell_total  <= w_slot_new.sell;
            r_out_item.sym_value_total <= w_slot_new.value;
            r_out_item.sym_low_price   <= w_slot_new.low;
            r_out_item.sym_high_price  <= w_slot_new.high;
            r_out_item.sym_seen        <= w_old_seen || (w_apply && r_in_range);
            r_out_item.all_buy_total   <= w_port_new.buy;
            r_out_item.all_sell_total  <= w_port_new.sell;
            r_out_item.all_value_total <= w_port_new.value;
            r_out_item.all_low_price   <= w_port_new.low;
            r_out_item.all_high_price  <= w_port_new.high;
        end
    end

    // no item taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("item accepted during clearing pass");

    // an accepted item always goes to its update cycle
    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_UPDATE))
        else $error("accepted item did not reach update");

    // a full, stalled output register holds the pending update back
    a_stall_holds_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPDATE) && r_out_valid && !i_out_ready) |=> (r_state == S_UPDATE))
        else $error("update overwrote a waiting result");

    // portfolio value total never decreases
    a_port_value_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_port.value >= $past(r_port.value)))
        else $error("portfolio value total decreased");

endmodule
